// ===== src/interrupt_slot_bitmap_allocator_core_defines.svh =====
// Assertion macros shared by the slot allocator checker.
`ifndef INTERRUPT_SLOT_BITMAP_ALLOCATOR_CORE_DEFINES_SVH
`define INTERRUPT_SLOT_BITMAP_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define ISBA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define ISBA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define ISBA_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/isba_pkg.sv =====
// Package of the interrupt slot allocator: constants, command codes and beat types.
`default_nettype none
package isba_pkg;

  localparam int NUM_SLOTS = 32;

  // Slots that exist in the pool
  localparam logic [31:0] POOL_MASK =
    (NUM_SLOTS >= 32) ? 32'hffff_ffff : ((32'd1 << NUM_SLOTS) - 32'd1);

  localparam logic [1:0] CMD_COUNT = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_BLOCK = 2'd2;
  localparam logic [1:0] CMD_FREE  = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [5:0]        count;
    logic signed [7:0] slot;
  } in_beat_t;

  typedef struct packed {
    logic       status;
    logic       slot_valid;
    logic [4:0] slot_index;
    logic [5:0] free_count;
    logic       last;
  } out_beat_t;

endpackage
`default_nettype wire

// ===== src/interrupt_slot_bitmap_allocator_core.sv =====
// Interrupt slot bitmap allocator: command decode, slot scan and block search.
//
// Usage:
//   A command beat (in_beat) is taken at a rising edge where start is high
//   and busy is low. Results appear on out_beat, each marked by out_strobe
//   high for a single cycle; the last result of a command has last set. The
//   receiver has no way to stall, so every strobed beat must be captured.
// Latency and throughput:
//   Count free, free one slot, failed any-slot allocations and empty ones:
//   one result in the cycle after the command; busy stays low, so commands
//   of this kind can be issued every cycle.
//   Allocate any n: the scanner steps one slot per cycle from slot 0 and
//   emits a beat for each free slot it claims.
//   Aligned block of n: the block checker tests one candidate base per
//   cycle (shift of the block mask and one compare). Both keep busy high
//   while they run, so no new command is taken until they finish.
// Reset:
//   rst_n low (synchronous) marks every slot free, returns to idle and
//   drops out_strobe.
`default_nettype none
module interrupt_slot_bitmap_allocator_core (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire isba_pkg::in_beat_t in_beat,
  output logic              out_strobe,
  output isba_pkg::out_beat_t out_beat
);
  import isba_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_BLOCK = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [31:0] used_r, used_nxt;
  logic [5:0]  free_r, free_nxt;
  logic [5:0]  n_r, n_nxt;
  logic [5:0]  rem_r, rem_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [5:0]  base_r, base_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic        strobe_r, strobe_nxt;
  out_beat_t   out_r, out_nxt;

  logic [31:0] low_mask;
  logic [6:0]  block_end;
  logic        slot_ok;

  // Block mask of n ones at base 0; n of 32 or more gives the full word
  assign low_mask = (in_beat.count >= 6'd32) ? 32'hffff_ffff
                  : ((32'd1 << in_beat.count[4:0]) - 32'd1);
  assign block_end = {1'b0, base_r} + {1'b0, n_r};
  assign slot_ok = (in_beat.slot[7] == 1'b0) && (in_beat.slot[6:0] < 7'(NUM_SLOTS));

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    used_nxt   = used_r;
    free_nxt   = free_r;
    n_nxt      = n_r;
    rem_nxt    = rem_r;
    idx_nxt    = idx_r;
    base_nxt   = base_r;
    mask_nxt   = mask_r;
    strobe_nxt = 1'b0;
    out_nxt    = out_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_nxt.status     = 1'b0;
          out_nxt.slot_valid = 1'b0;
          out_nxt.slot_index = 5'd0;
          out_nxt.free_count = free_r;
          out_nxt.last       = 1'b1;
          case (in_beat.cmd)
            CMD_COUNT: begin
              strobe_nxt = 1'b1;
            end
            CMD_ALLOC: begin
              if (free_r < in_beat.count) begin
                out_nxt.status = 1'b1;
                strobe_nxt     = 1'b1;
              end else if (in_beat.count == 6'd0) begin
                strobe_nxt = 1'b1;
              end else begin
                rem_nxt   = in_beat.count;
                idx_nxt   = 5'd0;
                free_nxt  = free_r - in_beat.count;
                state_nxt = ST_SCAN;
              end
            end
            CMD_BLOCK: begin
              if (in_beat.count == 6'd0) begin
                out_nxt.slot_valid = 1'b1;
                strobe_nxt         = 1'b1;
              end else begin
                n_nxt     = in_beat.count;
                base_nxt  = 6'd0;
                mask_nxt  = low_mask & POOL_MASK;
                state_nxt = ST_BLOCK;
              end
            end
            CMD_FREE: begin
              if (slot_ok && used_r[in_beat.slot[4:0]]) begin
                used_nxt[in_beat.slot[4:0]] = 1'b0;
                out_nxt.free_count          = free_r + 6'd1;
                free_nxt                    = free_r + 6'd1;
              end
              strobe_nxt = 1'b1;
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      // One slot per cycle; free_r already holds the count after the command
      ST_SCAN: begin
        if (!used_r[idx_r]) begin
          used_nxt[idx_r]    = 1'b1;
          out_nxt.status     = 1'b0;
          out_nxt.slot_valid = 1'b1;
          out_nxt.slot_index = idx_r;
          out_nxt.free_count = free_r;
          out_nxt.last       = (rem_r == 6'd1);
          strobe_nxt         = 1'b1;
          rem_nxt            = rem_r - 6'd1;
          if (rem_r == 6'd1) begin
            state_nxt = ST_IDLE;
          end
        end
        idx_nxt = idx_r + 5'd1;
      end
      // One candidate base per cycle
      ST_BLOCK: begin
        out_nxt.slot_index = 5'd0;
        out_nxt.last       = 1'b1;
        if (block_end > 7'(NUM_SLOTS)) begin
          out_nxt.status     = 1'b1;
          out_nxt.slot_valid = 1'b0;
          out_nxt.free_count = free_r;
          strobe_nxt         = 1'b1;
          state_nxt          = ST_IDLE;
        end else if ((used_r & mask_r) == 32'd0) begin
          used_nxt           = used_r | mask_r;
          free_nxt           = free_r - n_r;
          out_nxt.status     = 1'b0;
          out_nxt.slot_valid = 1'b1;
          out_nxt.slot_index = base_r[4:0];
          out_nxt.free_count = free_r - n_r;
          strobe_nxt         = 1'b1;
          state_nxt          = ST_IDLE;
        end else begin
          base_nxt = block_end[5:0];
          mask_nxt = (mask_r << n_r) & POOL_MASK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      used_r   <= 32'd0;
      free_r   <= 6'(NUM_SLOTS);
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      free_r   <= free_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    idx_r  <= idx_nxt;
    base_r <= base_nxt;
    mask_r <= mask_nxt;
    out_r  <= out_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = strobe_r;
  assign out_beat   = out_r;

endmodule
`default_nettype wire

// ===== src/isba_checker.sv =====
// Port-level checker for the slot allocator, bound to the allocator core.
`default_nettype none
`include "interrupt_slot_bitmap_allocator_core_defines.svh"
module isba_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 start,
  input wire                 busy,
  input wire                 out_strobe,
  input wire isba_pkg::out_beat_t out_beat
);
  import isba_pkg::*;

  // A command is either answered at once or keeps the block busy
  `ISBA_ASSERT_NXT(a_cmd_progress, start && !busy, out_strobe || busy, "command left no trace")
  // More beats of a command only follow while the block is still busy
  `ISBA_ASSERT_IMP(a_more_busy, out_strobe && !out_beat.last, busy, "non-final beat while idle")
  // A failure is a single beat with no slot
  `ISBA_ASSERT_IMP(a_fail_shape, out_strobe && out_beat.status,
                   out_beat.last && !out_beat.slot_valid, "malformed failure beat")
  // Free count never exceeds the pool
  `ISBA_ASSERT_IMP(a_free_range, out_strobe, out_beat.free_count <= 6'(NUM_SLOTS),
                   "free count above pool size")
  // Reset leaves the block idle and quiet
  `ISBA_ASSERT_RST(a_reset_idle, !rst_n, !busy && !out_strobe, "not idle after reset")

endmodule

bind interrupt_slot_bitmap_allocator_core isba_checker u_isba_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of the interrupt slot bitmap allocator: directed table, then random.
`default_nettype none
module tb_top;
  import isba_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 2 * NUM_SLOTS + 8;
  localparam int RANDOM_ITEMS = 380;

  typedef struct {
    in_beat_t  beat;
    logic      pinned;
    out_beat_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_beat_t  in_beat = '0;
  logic      out_strobe;
  out_beat_t out_beat;

  // Typed-in expectation travelling alongside the command beat
  logic      pin_en = 1'b0;
  out_beat_t pin_beat = '0;

  // Predicted allocator state and outstanding result beats
  logic [31:0] slot_map = '0;
  out_beat_t   pending_beats [$];

  int fail_cnt = 0;
  int cycle_cnt = 0;
  int beats_seen = 0;
  int cmds_taken [4] = '{0, 0, 0, 0};
  int sweeps_done = 0;
  int send_idle_pct = 14;

  interrupt_slot_bitmap_allocator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_beat    (in_beat),
    .out_strobe (out_strobe),
    .out_beat   (out_beat)
  );

  always #5 clk = ~clk;

  function automatic logic [5:0] free_slots();
    return 6'($countones(~slot_map));
  endfunction

  function automatic in_beat_t mk_beat(input logic [1:0] cmd, input int n, input int s);
    in_beat_t b;
    b.cmd   = cmd;
    b.count = n[5:0];
    b.slot  = s[7:0];
    return b;
  endfunction

  function automatic dir_row_t mk_row(input logic [1:0] cmd, input int n, input int s,
                                      input logic pinned, input logic st, input logic vld,
                                      input int idx, input int fc);
    dir_row_t r;
    r.beat              = mk_beat(cmd, n, s);
    r.pinned            = pinned;
    r.want.status       = st;
    r.want.slot_valid   = vld;
    r.want.slot_index   = idx[4:0];
    r.want.free_count   = fc[5:0];
    r.want.last         = 1'b1;
    return r;
  endfunction

  // Advance the predicted bitmap by one command and queue the beats it yields
  task automatic apply_command(input in_beat_t b, input logic pinned, input out_beat_t pin);
    int        n;
    int        s;
    int        base;
    logic      hit;
    logic [63:0] wide;
    logic [31:0] blk;
    out_beat_t r;
    out_beat_t res [$];
    n = b.count;
    s = b.slot;
    cmds_taken[b.cmd]++;
    r = '0;
    r.last = 1'b1;
    case (b.cmd)
      CMD_COUNT: begin
        r.free_count = free_slots();
        res.push_back(r);
      end
      CMD_ALLOC: begin
        if (free_slots() < n) begin
          r.status     = 1'b1;
          r.free_count = free_slots();
          res.push_back(r);
        end else if (n == 0) begin
          r.free_count = free_slots();
          res.push_back(r);
        end else begin
          // lowest free slots first, in rising order
          for (int i = 0; i < NUM_SLOTS && res.size() < n; i++) begin
            if (!slot_map[i]) begin
              slot_map[i]  = 1'b1;
              r.slot_valid = 1'b1;
              r.slot_index = i[4:0];
              r.last       = 1'b0;
              res.push_back(r);
            end
          end
          foreach (res[j]) res[j].free_count = free_slots();
          res[res.size() - 1].last = 1'b1;
        end
      end
      CMD_BLOCK: begin
        if (n == 0) begin
          r.slot_valid = 1'b1;
        end else begin
          hit = 1'b0;
          for (base = 0; base + n <= NUM_SLOTS && !hit; base += n) begin
            wide = ((64'd1 << n) - 64'd1) << base;
            blk  = (n >= 32) ? 32'hffff_ffff : wide[31:0];
            blk  = blk & POOL_MASK;
            if ((slot_map & blk) == 32'd0) begin
              slot_map     = slot_map | blk;
              hit          = 1'b1;
              r.slot_valid = 1'b1;
              r.slot_index = base[4:0];
            end
          end
          r.status = !hit;
        end
        r.free_count = free_slots();
        res.push_back(r);
      end
      default: begin
        // out-of-pool indices, negative ones included, leave the map alone
        if (s >= 0 && s < NUM_SLOTS) slot_map[s] = 1'b0;
        r.free_count = free_slots();
        res.push_back(r);
      end
    endcase
    if (pinned) pending_beats.push_back(pin);
    else foreach (res[j]) pending_beats.push_back(res[j]);
  endtask

  // Compare one strobed result beat with the oldest outstanding one
  task automatic check_beat(input out_beat_t got);
    out_beat_t want;
    beats_seen++;
    if (pending_beats.size() == 0) begin
      $error("result beat with nothing outstanding: %p", got);
      fail_cnt++;
    end else begin
      want = pending_beats.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fail_cnt++;
      end
      if (got.slot_valid !== want.slot_valid) begin
        $error("slot_valid: expected %0d, got %0d", want.slot_valid, got.slot_valid);
        fail_cnt++;
      end
      if (got.slot_index !== want.slot_index) begin
        $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
        fail_cnt++;
      end
      if (got.free_count !== want.free_count) begin
        $error("free_count: expected %0d, got %0d", want.free_count, got.free_count);
        fail_cnt++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        fail_cnt++;
      end
    end
  endtask

  // Monitor: pre-edge values decide acceptance and result capture
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt,
               pending_beats.size());
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_n && start && !busy) apply_command(in_beat, pin_en, pin_beat);
    if (rst_n && out_strobe) check_beat(out_beat);
  end

  // Offer one command beat, with random idle cycles ahead, and hold it until taken
  task automatic send_cmd(input in_beat_t b, input logic pinned, input out_beat_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      start   <= 1'b0;
      in_beat <= in_beat_t'($urandom());
      @(posedge clk);
    end
    start    <= 1'b1;
    in_beat  <= b;
    pin_en   <= pinned;
    pin_beat <= want;
    // busy is looked at mid-cycle, so the next rising edge is the accepting one
    @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_plain(input in_beat_t b);
    send_cmd(b, 1'b0, '0);
  endtask

  initial begin
    dir_row_t  dir_rows [$];
    int        sent;
    int        roll;
    int        n;
    int        s;
    int        j;
    int        order [$];
    int        used [$];
    logic [1:0] cmd;

    // after reset: empty pool, empty requests, oversize requests, stray frees
    dir_rows.push_back(mk_row(CMD_COUNT, 0, 0, 1, 0, 0, 0, 32));
    dir_rows.push_back(mk_row(CMD_ALLOC, 0, 0, 1, 0, 0, 0, 32));
    dir_rows.push_back(mk_row(CMD_BLOCK, 0, 0, 1, 0, 1, 0, 32));
    dir_rows.push_back(mk_row(CMD_ALLOC, 40, 0, 1, 1, 0, 0, 32));
    dir_rows.push_back(mk_row(CMD_BLOCK, 63, 0, 1, 1, 0, 0, 32));
    dir_rows.push_back(mk_row(CMD_FREE, 0, -128, 1, 0, 0, 0, 32));
    dir_rows.push_back(mk_row(CMD_FREE, 0, 127, 1, 0, 0, 0, 32));
    dir_rows.push_back(mk_row(CMD_FREE, 0, 32, 1, 0, 0, 0, 32));
    dir_rows.push_back(mk_row(CMD_FREE, 0, -1, 1, 0, 0, 0, 32));
    // whole pool as one block, then everything fails
    dir_rows.push_back(mk_row(CMD_BLOCK, 32, 0, 1, 0, 1, 0, 0));
    dir_rows.push_back(mk_row(CMD_ALLOC, 1, 0, 1, 1, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_BLOCK, 1, 0, 1, 1, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_ALLOC, 32, 0, 1, 1, 0, 0, 0));
    // end slots, and freeing a slot that is already free
    dir_rows.push_back(mk_row(CMD_FREE, 0, 31, 1, 0, 0, 0, 1));
    dir_rows.push_back(mk_row(CMD_FREE, 0, 0, 1, 0, 0, 0, 2));
    dir_rows.push_back(mk_row(CMD_FREE, 0, 0, 1, 0, 0, 0, 2));
    dir_rows.push_back(mk_row(CMD_BLOCK, 1, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_ALLOC, 1, 0, 0, 0, 0, 0, 0));
    // misaligned hole refuses a block of two, aligned hole takes it
    dir_rows.push_back(mk_row(CMD_FREE, 0, 5, 1, 0, 0, 0, 1));
    dir_rows.push_back(mk_row(CMD_BLOCK, 2, 0, 1, 1, 0, 0, 1));
    dir_rows.push_back(mk_row(CMD_FREE, 0, 4, 1, 0, 0, 0, 2));
    dir_rows.push_back(mk_row(CMD_BLOCK, 2, 0, 0, 0, 0, 0, 0));
    // scattered holes filled by one multi-beat allocation
    dir_rows.push_back(mk_row(CMD_FREE, 0, 17, 1, 0, 0, 0, 1));
    dir_rows.push_back(mk_row(CMD_FREE, 0, 20, 1, 0, 0, 0, 2));
    dir_rows.push_back(mk_row(CMD_ALLOC, 2, 0, 0, 0, 0, 0, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_cmd(dir_rows[i].beat, dir_rows[i].pinned, dir_rows[i].want);

    // random part in three idling phases
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      send_idle_pct = (sent < RANDOM_ITEMS / 3) ? 14 :
                      (sent < 2 * RANDOM_ITEMS / 3) ? 53 : 0;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        // free the whole pool in shuffled order, then ask for something big
        order.delete();
        for (int i = 0; i < NUM_SLOTS; i++) order.push_back(i);
        while (order.size() > 0) begin
          j = $urandom_range(0, order.size() - 1);
          send_plain(mk_beat(CMD_FREE, $urandom_range(0, 32), order[j]));
          order.delete(j);
          sent++;
        end
        case ($urandom_range(0, 3))
          0: send_plain(mk_beat(CMD_ALLOC, 32, $urandom()));
          1: send_plain(mk_beat(CMD_BLOCK, 32, $urandom()));
          2: send_plain(mk_beat(CMD_BLOCK, 16, $urandom()));
          default: send_plain(mk_beat(CMD_ALLOC, $urandom_range(8, 32), $urandom()));
        endcase
        sent++;
        sweeps_done++;
      end else begin
        roll = $urandom_range(0, 99);
        cmd  = (roll < 10) ? CMD_COUNT : (roll < 40) ? CMD_ALLOC :
               (roll < 65) ? CMD_BLOCK : CMD_FREE;
        n = $urandom_range(0, 32);
        s = $urandom();
        roll = $urandom_range(0, 99);
        if (cmd == CMD_ALLOC) begin
          n = (roll < 70) ? $urandom_range(1, 4) : (roll < 90) ? $urandom_range(0, 32) :
              (roll < 95) ? 0 : $urandom_range(33, 63);
        end else if (cmd == CMD_BLOCK) begin
          n = (roll < 60) ? (1 << $urandom_range(0, 5)) : (roll < 90) ? $urandom_range(1, 32) :
              (roll < 95) ? 0 : $urandom_range(33, 63);
        end else if (cmd == CMD_FREE) begin
          // slots in use, slots anywhere in the pool, or stray indices
          used.delete();
          for (int i = 0; i < NUM_SLOTS; i++) if (slot_map[i]) used.push_back(i);
          if (roll < 45 && used.size() > 0) s = used[$urandom_range(0, used.size() - 1)];
          else if (roll < 75) s = $urandom_range(0, NUM_SLOTS - 1);
        end
        send_plain(mk_beat(cmd, n, s));
        sent++;
      end
    end
    start   <= 1'b0;
    in_beat <= '0;

    // drain, then let any late stray beat show up
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d commands: %0d count, %0d alloc, %0d block, %0d free",
             cmds_taken[0] + cmds_taken[1] + cmds_taken[2] + cmds_taken[3],
             cmds_taken[CMD_COUNT], cmds_taken[CMD_ALLOC], cmds_taken[CMD_BLOCK],
             cmds_taken[CMD_FREE]);
    $display("checked %0d result beats, %0d full-pool sweeps, %0d cycles",
             beats_seen, sweeps_done, cycle_cnt);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== interrupt_slot_bitmap_allocator_core.f =====
+incdir+src
src/isba_pkg.sv
src/interrupt_slot_bitmap_allocator_core.sv
src/isba_checker.sv
tb/tb_top.sv
